/* src/emgrma_pkg.sv */
package emgrma_pkg;

  localparam int unsigned WINDOW_DEF = 16;
  localparam int unsigned NCH        = 8;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned MEAN_W     = 16;
  localparam int unsigned CHSUM_W    = 11;
  localparam int unsigned RECIP_SH   = 24;
  localparam int unsigned RECIP_W    = RECIP_SH + 1;

  typedef struct packed {
    logic                update;
    logic [SAMPLE_W-1:0] sample;
  } fe_item_t;

  function automatic logic [SAMPLE_W-1:0] rect8(logic signed [CH_W-1:0] v);
    logic [CH_W-1:0] neg;
    neg = CH_W'(-v);
    return v[CH_W-1] ? SAMPLE_W'(neg) : SAMPLE_W'(v);
  endfunction

endpackage

/* src/emgrma_ram.sv */
module emgrma_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/emgrma_front.sv */
module emgrma_front
  import emgrma_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_update_i,
  input  logic [NCH*CH_W-1:0]  in_ch_i,
  output fe_item_t             item_o
);

  logic               zero_fill_q, zero_fill_d;
  logic [CHSUM_W-1:0] chsum;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    zero_fill_d = zero_fill_q;
    if (cfg_valid_i) begin
      zero_fill_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_fill_q <= 1'b0;
    end else begin
      zero_fill_q <= zero_fill_d;
    end
  end

  // rectify and sum the channels, divide by the channel count
  always_comb begin
    chsum = '0;
    for (int c = 0; c < NCH; c++) begin
      chsum = chsum + CHSUM_W'(rect8(in_ch_i[c*CH_W +: CH_W]));
    end
  end

  always_comb begin
    item_o.update = in_update_i;
    item_o.sample = zero_fill_q ? '0 : SAMPLE_W'(chsum >> 3);
    if (!in_valid_i) begin
      item_o.update = 1'b0;
    end
  end

endmodule

/* src/emgrma_fifo.sv */
module emgrma_fifo
  import emgrma_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fe_item_t push_item_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output fe_item_t pop_item_o
);

  fe_item_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* src/emgrma_back.sv */
module emgrma_back
  import emgrma_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_vld_i,
  input  fe_item_t          q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MEAN_W-1:0] out_mean_o
);

  localparam int unsigned SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_MAX = 128 * WINDOW;
  localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned X_W     = SUM_W + 8;
  localparam int unsigned QW_W    = 25;
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'((64'd1 << RECIP_SH) / WINDOW);
  localparam logic [QW_W-1:0]    W_Q      = QW_W'(WINDOW);
  localparam logic [QW_W-1:0]    W2_Q     = QW_W'(2 * WINDOW);
  localparam logic [SUM_W-1:0]   SUM_MAXQ = SUM_W'(SUM_MAX);
  localparam logic [SLOT_W:0]    SLOT_LIM = (SLOT_W + 1)'(WINDOW);
  localparam logic [SLOT_W-1:0]  SLOT_TOP = SLOT_W'(WINDOW - 1);

  logic                adv, pop, we;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [WINDOW-1:0]   vld_q;
  logic [SAMPLE_W-1:0] rdata;

  logic                s1_vld_q, s1_upd_q;
  logic [SAMPLE_W-1:0] s1_smp_q;
  logic [SLOT_W-1:0]   s1_addr_q;
  logic                vld_rd_q, fwd_q;
  logic [SAMPLE_W-1:0] fwd_dat_q;
  logic [SAMPLE_W-1:0] old;
  logic [SUM_W-1:0]    sum_q, sum_d;

  logic                s2_vld_q;
  logic [SUM_W-1:0]    s2_sum_q;
  logic                s3_vld_q;
  logic [SUM_W-1:0]    s3_sum_q;
  logic [PROD_W-1:0]   s3_prod_q;
  logic                s4_vld_q;
  logic [MEAN_W-1:0]   s4_qe_q;
  logic [QW_W-1:0]     s4_qw_q;
  logic [X_W-1:0]      s4_x_q;
  logic [MEAN_W-1:0]   qe;
  logic [QW_W-1:0]     rem;
  logic                out_vld_q;
  logic [MEAN_W-1:0]   mean_q;

  assign adv     = !out_vld_q || out_ready_i;
  assign pop     = adv && q_vld_i;
  assign q_pop_o = pop;
  assign we      = adv && s1_vld_q && s1_upd_q;

  always_comb begin
    slot_d = slot_q;
    if (pop && q_item_i.update) begin
      slot_d = (slot_q == SLOT_TOP) ? '0 : slot_q + 1'b1;
    end
  end

  emgrma_ram #(
    .DW    (SAMPLE_W),
    .DEPTH (WINDOW),
    .AW    (SLOT_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_smp_q),
    .re_i    (adv),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  // entry being replaced: bypass a same-slot write, never-written slots read as zero
  always_comb begin
    old = vld_rd_q ? rdata : '0;
    if (fwd_q) begin
      old = fwd_dat_q;
    end
    sum_d = sum_q;
    if (s1_vld_q && s1_upd_q) begin
      sum_d = sum_q - SUM_W'(old) + SUM_W'(s1_smp_q);
    end
  end

  assign qe  = MEAN_W'(s3_prod_q >> 16);
  assign rem = QW_W'(s4_x_q) - s4_qw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= '0;
      vld_q     <= '0;
      sum_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      fwd_q     <= 1'b0;
      vld_rd_q  <= 1'b0;
    end else if (adv) begin
      slot_q    <= slot_d;
      sum_q     <= sum_d;
      if (we) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
      vld_rd_q  <= vld_q[slot_q];
      fwd_q     <= we && (s1_addr_q == slot_q);
      s1_vld_q  <= pop;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_upd_q  <= q_item_i.update;
      s1_smp_q  <= q_item_i.sample;
      s1_addr_q <= slot_q;
      fwd_dat_q <= s1_smp_q;
      s2_sum_q  <= sum_d;
      s3_sum_q  <= s2_sum_q;
      s3_prod_q <= PROD_W'(s2_sum_q) * PROD_W'(RECIP);
      s4_qe_q   <= qe;
      s4_qw_q   <= QW_W'(qe) * W_Q;
      s4_x_q    <= X_W'(s3_sum_q) << 8;
      mean_q    <= s4_qe_q + MEAN_W'(rem >= W_Q);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_mean_o  = mean_q;

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_MAXQ)
    else $error("window sum out of range");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, slot_q} < SLOT_LIM)
    else $error("write slot out of range");

  a_recip_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_vld_q |-> (s4_x_q >= X_W'(s4_qw_q)) && (rem < W2_Q))
    else $error("reciprocal quotient estimate off by more than one");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (sum_q == $past(sum_q)) && (slot_q == $past(slot_q)))
    else $error("ring state changed during stall");

endmodule

/* src/emg_rectified_moving_average.sv */
// Eight-channel EMG rectified-mean boxcar filter. Each item on the slave stream
// carries eight signed 8-bit samples in tdata and an update flag in tuser; when
// update is set the block rectifies the channels, forms floor(sum/8) (or zero when
// the zero_fill register is set) and replaces the oldest entry of a WINDOW-deep
// ring. Every item yields one result, floor(ring_sum*256/WINDOW) as unsigned
// fixed point with 8 fraction bits. One item is accepted per cycle while the queue
// is not full; results pass through stages s1 to s4 and the output register.
// Throughput is set by the ring read-modify-write on a RAM with separate read and
// write ports, which runs once per cycle unless the output stalls, with a bypass
// for a same-slot write. Ring entries read as zero until first written, tracked
// by per-entry valid bits, so there is no clearing pass after reset.
module emg_rectified_moving_average
  import emgrma_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,     // zero_fill
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [NCH*CH_W-1:0] s_axis_tdata,   // ch0, ch1, ..., ch7
  input  logic [0:0]          s_axis_tuser,   // update
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [MEAN_W-1:0]   m_axis_tdata    // mean_q8
);

  fe_item_t fe_item, q_item;
  logic     q_full, q_empty, q_pop, in_acc;

  assign s_axis_tready = !q_full;
  assign in_acc        = s_axis_tvalid && !q_full;

  emgrma_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_update_i (s_axis_tuser[0]),
    .in_ch_i     (s_axis_tdata),
    .item_o      (fe_item)
  );

  emgrma_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_item_i (fe_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_item_o  (q_item)
  );

  emgrma_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (!q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_mean_o  (m_axis_tdata)
  );

endmodule

/* tb/tb_emg_rectified_moving_average.sv */
module tb_emg_rectified_moving_average;
  import emgrma_pkg::*;

  localparam int unsigned CHAN_BITS    = NCH * CH_W;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic                 cfg_data_i    = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [CHAN_BITS-1:0] s_axis_tdata  = '0;   // ch0, ch1, ..., ch7
  logic [0:0]           s_axis_tuser  = '0;   // update
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [MEAN_W-1:0]    m_axis_tdata;         // mean_q8

  logic [SAMPLE_W-1:0] win_ring [WINDOW_DEF] = '{default: '0};
  int unsigned         win_slot    = 0;
  int unsigned         win_sum     = 0;
  logic                zero_fill_q = 1'b0;
  logic [MEAN_W-1:0]   expected_means[$];

  int unsigned cycle_cnt       = 0;
  int unsigned mismatches      = 0;
  int unsigned items_sent      = 0;
  int unsigned pushes          = 0;
  int unsigned zero_pushes     = 0;
  int unsigned results_checked = 0;
  int unsigned rx_hold_req     = 0;
  int unsigned rx_hold_left    = 0;
  bit          tx_quiet        = 1'b0;
  bit          rx_quiet        = 1'b0;

  emg_rectified_moving_average #(
    .WINDOW(WINDOW_DEF)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [MEAN_W-1:0] predict_mean(logic upd, logic [CHAN_BITS-1:0] chans);
    logic [CH_W-1:0]     raw;
    int unsigned         chan_sum;
    logic [SAMPLE_W-1:0] sample;
    chan_sum = 0;
    sample   = '0;
    if (upd) begin
      pushes++;
      if (zero_fill_q) begin
        zero_pushes++;
      end else begin
        for (int c = 0; c < NCH; c++) begin
          raw = chans[c*CH_W +: CH_W];
          chan_sum += raw[CH_W-1] ? (256 - int'(raw)) : int'(raw);
        end
        sample = SAMPLE_W'(chan_sum / NCH);
      end
      win_sum           = win_sum - win_ring[win_slot] + sample;
      win_ring[win_slot] = sample;
      win_slot          = (win_slot + 1 == WINDOW_DEF) ? 0 : win_slot + 1;
    end
    return MEAN_W'((win_sum * 256) / WINDOW_DEF);
  endfunction

  // check results, then predict accepted items and track register writes
  always @(posedge clk_i) begin
    logic [MEAN_W-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_means.size() == 0) begin
          $error("unexpected result: mean_q8 expected none, actual %0d", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_means.pop_back();
          results_checked++;
          if (m_axis_tdata !== want) begin
            $error("mean_q8 expected %0d, actual %0d", want, m_axis_tdata);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_means.push_front(predict_mean(s_axis_tuser[0], s_axis_tdata));
      if (cfg_valid_i && cfg_ready_o)
        zero_fill_q = cfg_data_i;
    end
  end

  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready <= rx_quiet || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [CHAN_BITS-1:0] rand_chans();
    logic [CHAN_BITS-1:0] chans;
    for (int c = 0; c < NCH; c++) begin
      case ($urandom_range(9))
        0:       chans[c*CH_W +: CH_W] = 8'h80;
        1:       chans[c*CH_W +: CH_W] = 8'h7F;
        2:       chans[c*CH_W +: CH_W] = 8'h00;
        3:       chans[c*CH_W +: CH_W] = 8'hFF;
        default: chans[c*CH_W +: CH_W] = CH_W'($urandom);
      endcase
    end
    return chans;
  endfunction

  task automatic send_item(input logic upd, input logic [CHAN_BITS-1:0] chans);
    while (!tx_quiet && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= chans;
    s_axis_tuser[0] <= upd;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_zero_fill(input logic value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_item(1'b1, '0);
    send_item(1'b1, {NCH{8'h80}});
    send_item(1'b1, {NCH{8'h7F}});
    send_item(1'b1, {{(NCH-1){8'h7F}}, 8'h80});
    send_item(1'b1, {NCH{8'hFF}});
    send_item(1'b1, {{(NCH-1){8'h00}}, 8'h07});
    send_item(1'b0, {NCH{8'h80}});
    send_item(1'b1, {4{8'h81, 8'h7F}});
    // fill the whole window with the largest sample
    repeat (WINDOW_DEF) send_item(1'b1, {NCH{8'h80}});
    send_item(1'b0, rand_chans());
  endtask

  task automatic test_zero_fill();
    write_zero_fill(1'b1);
    send_item(1'b1, {NCH{8'h80}});
    repeat (20) send_item($urandom_range(9) != 0, rand_chans());
    send_item(1'b0, {NCH{8'h7F}});
    write_zero_fill(1'b0);
    repeat (5) send_item(1'b1, rand_chans());
  endtask

  task automatic test_backpressure();
    rx_hold_req = 300;
    tx_quiet    = 1'b1;
    repeat (80) send_item($urandom_range(9) != 0, rand_chans());
    tx_quiet = 1'b0;
    drain_results();
    repeat (10) send_item($urandom_range(9) != 0, rand_chans());
  endtask

  task automatic test_random();
    for (int n = 0; n < 360; n++) begin
      if (n == 150) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      if (n == 250) begin
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
      end
      if (n == 300) write_zero_fill(1'b1);
      if (n == 340) write_zero_fill(1'b0);
      if (n == 350) drain_results();
      send_item($urandom_range(99) < 85, rand_chans());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_zero_fill();
    test_backpressure();
    test_random();
    drain_results();
    $display("Sent %0d items (%0d window pushes, %0d of them zero-filled), checked %0d results.",
             items_sent, pushes, zero_pushes, results_checked);
    $display("Covered extreme samples, full window, zero-fill mode, idle gaps and back-pressure.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/emgrma_pkg.sv
src/emgrma_ram.sv
src/emgrma_front.sv
src/emgrma_fifo.sv
src/emgrma_back.sv
src/emg_rectified_moving_average.sv
tb/tb_emg_rectified_moving_average.sv
